@@ rtl/core/cca_pkg.sv @@
// shared types and constants for the cluster chain allocator
`timescale 1ns / 1ps

package cca_pkg;

  localparam int CMD_W    = 3;
  localparam int IDX_W    = 10;
  localparam int ENTRY_W  = IDX_W + 1;
  localparam int CUR_W    = IDX_W + 1;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LINK   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FREE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FORMAT = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BROKEN = 2'd2;

  localparam int FREE_BIT = IDX_W;

  localparam logic [ENTRY_W-1:0] FREE_ENTRY = 11'h400;
  localparam logic [ENTRY_W-1:0] END_ENTRY  = 11'h000;

  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    cluster;
    logic                efree;
    logic                eend;
  } res_t;

endpackage

@@ rtl/core/cca_table.sv @@
// link table memory, one write port and one registered read port
`timescale 1ns / 1ps

module cca_table
  import cca_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic               clk,
  input  mem_req_t           mem_req,
  output logic [ENTRY_W-1:0] rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_data_r <= mem[mem_req.rd_addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/cca_out.sv @@
// result register on the output channel
`timescale 1ns / 1ps

module cca_out
  import cca_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  res_t                res,
  output logic                res_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [IDX_W-1:0]    out_cluster_out,
  output logic                out_entry_free,
  output logic                out_entry_end
);

  logic out_valid_r;
  res_t res_r;

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = res_r.status;
  assign out_cluster_out = res_r.cluster;
  assign out_entry_free  = res_r.efree;
  assign out_entry_end   = res_r.eend;

endmodule

@@ rtl/core/cca_ctrl.sv @@
// command sequencer: scan, chain walk, query, link and sweeps over the table
`timescale 1ns / 1ps

module cca_ctrl
  import cca_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [IDX_W-1:0]   in_cluster_index,
  input  logic [IDX_W-1:0]   in_next_index,
  output mem_req_t           mem_req,
  input  logic [ENTRY_W-1:0] rd_data,
  output logic               res_valid,
  output res_t               res,
  input  logic               res_ready
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CK   = 3'd3;
  localparam logic [2:0] S_FMT  = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  localparam logic [CUR_W-1:0] DEPTH_C = CUR_W'(DEPTH);
  localparam logic [CUR_W-1:0] LAST_C  = CUR_W'(DEPTH - 1);

  logic [2:0]       state_r, state_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [CUR_W-1:0] cur_r, cur_nxt;
  logic [CUR_W-1:0] low_r, low_nxt;
  res_t             res_r, res_nxt;

  logic               cur_in_rng;
  logic [ENTRY_W-1:0] entry;
  logic [IDX_W-1:0]   entry_next;

  assign cur_in_rng = cur_r < DEPTH_C;
  assign entry      = cur_in_rng ? rd_data : END_ENTRY;
  assign entry_next = entry[IDX_W-1:0];

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    cur_nxt   = cur_r;
    low_nxt   = low_r;
    res_nxt   = res_r;
    mem_req   = '0;

    unique case (state_r)
      S_INIT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = cur_r[IDX_W-1:0];
        mem_req.wr_data = (cur_r == '0) ? END_ENTRY : FREE_ENTRY;
        if (cur_r == LAST_C) begin
          low_nxt   = CUR_W'(1);
          cur_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cur_nxt = cur_r + CUR_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_command;
          cur_nxt = {1'b0, in_cluster_index};
          res_nxt = '0;
          unique case (in_command) inside
            CMD_ALLOC: begin
              cur_nxt   = low_r;
              state_nxt = S_RD;
            end
            CMD_LINK: begin
              if ({1'b0, in_cluster_index} < DEPTH_C) begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = in_cluster_index;
                mem_req.wr_data = {1'b0, in_next_index};
              end
              state_nxt = S_RESP;
            end
            CMD_FREE, CMD_QUERY: begin
              state_nxt = S_RD;
            end
            CMD_FORMAT: begin
              cur_nxt   = '0;
              state_nxt = S_FMT;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_RD: begin
        mem_req.rd_en   = cur_in_rng;
        mem_req.rd_addr = cur_r[IDX_W-1:0];
        state_nxt       = S_CK;
      end
      S_CK: begin
        unique case (cmd_r)
          CMD_ALLOC: begin
            if (!cur_in_rng) begin
              res_nxt.status = ST_FULL;
              low_nxt        = DEPTH_C;
              state_nxt      = S_RESP;
            end else if (entry[FREE_BIT]) begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = cur_r[IDX_W-1:0];
              mem_req.wr_data = END_ENTRY;
              res_nxt.status  = ST_OK;
              res_nxt.cluster = cur_r[IDX_W-1:0];
              low_nxt         = cur_r + CUR_W'(1);
              state_nxt       = S_RESP;
            end else begin
              cur_nxt   = cur_r + CUR_W'(1);
              state_nxt = S_RD;
            end
          end
          CMD_FREE: begin
            if (!cur_in_rng) begin
              state_nxt = S_RESP;
            end else if (entry[FREE_BIT]) begin
              res_nxt.status = ST_BROKEN;
              state_nxt      = S_RESP;
            end else begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = cur_r[IDX_W-1:0];
              mem_req.wr_data = FREE_ENTRY;
              if (cur_r < low_r) begin
                low_nxt = cur_r;
              end
              if (entry_next == '0) begin
                state_nxt = S_RESP;
              end else begin
                cur_nxt   = {1'b0, entry_next};
                state_nxt = S_RD;
              end
            end
          end
          CMD_QUERY: begin
            if (entry[FREE_BIT]) begin
              res_nxt.efree = 1'b1;
            end else begin
              res_nxt.cluster = entry_next;
              res_nxt.eend    = (entry_next == '0);
            end
            state_nxt = S_RESP;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_FMT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = cur_r[IDX_W-1:0];
        mem_req.wr_data = FREE_ENTRY;
        if (cur_r == LAST_C) begin
          low_nxt   = '0;
          state_nxt = S_RESP;
        end else begin
          cur_nxt = cur_r + CUR_W'(1);
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cur_r   <= '0;
      low_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      low_r   <= low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    res_r <= res_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;

endmodule

@@ rtl/core/cluster_chain_allocator.sv @@
// top level of the cluster chain allocator
// link writes one entry, query reads one, allocate scans up from the lowest-free hint,
// free walks the chain entry by entry, and format sweeps the whole table
// throughput: one transaction at a time, paced by the single read port of the link table
// reset: a clearing pass over the table marks entry 0 end of chain and all others free while
// input is stalled; the output register comes up empty
`timescale 1ns / 1ps

module cluster_chain_allocator
  import cca_pkg::*;
#(
  parameter int CLUSTER_COUNT = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [IDX_W-1:0]    in_cluster_index,
  input  logic [IDX_W-1:0]    in_next_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [IDX_W-1:0]    out_cluster_out,
  output logic                out_entry_free,
  output logic                out_entry_end
);

  localparam int DEPTH = (CLUSTER_COUNT < (1 << IDX_W)) ? CLUSTER_COUNT : (1 << IDX_W);

  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] rd_data;
  logic               res_valid;
  logic               res_ready;
  res_t               res;

  cca_table #(
    .DEPTH(DEPTH)
  ) u_table (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  cca_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_cluster_index (in_cluster_index),
    .in_next_index    (in_next_index),
    .mem_req          (mem_req),
    .rd_data          (rd_data),
    .res_valid        (res_valid),
    .res              (res),
    .res_ready        (res_ready)
  );

  cca_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res_valid),
    .res             (res),
    .res_ready       (res_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_cluster_out (out_cluster_out),
    .out_entry_free  (out_entry_free),
    .out_entry_end   (out_entry_end)
  );

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the cluster chain allocator
`timescale 1ns / 1ps

module testbench;
  import cca_pkg::*;

  localparam int CLUSTER_COUNT = 1024;
  localparam int TBL_DEPTH = (CLUSTER_COUNT < (1 << IDX_W)) ? CLUSTER_COUNT : (1 << IDX_W);
  localparam logic [IDX_W-1:0] IDX_MAX = '1;
  localparam logic [CMD_W-1:0] CMD_TOP = '1;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PRINT_LIMIT = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] in_command = '0;
  logic [IDX_W-1:0] in_cluster_index = '0;
  logic [IDX_W-1:0] in_next_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [IDX_W-1:0] out_cluster_out;
  logic out_entry_free;
  logic out_entry_end;

  logic [ENTRY_W-1:0] fat_table [TBL_DEPTH];
  res_t pending_results [$];
  int err_count = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  cluster_chain_allocator #(
    .CLUSTER_COUNT(CLUSTER_COUNT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_cluster_index(in_cluster_index),
    .in_next_index(in_next_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_cluster_out(out_cluster_out),
    .out_entry_free(out_entry_free),
    .out_entry_end(out_entry_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic res_t predict_fat_command(input logic [CMD_W-1:0] cmd,
                                              input logic [IDX_W-1:0] idx,
                                              input logic [IDX_W-1:0] nxt);
    res_t r;
    logic [ENTRY_W-1:0] e;
    logic [IDX_W-1:0] cur;
    int n;
    bit done;
    r = '0;
    done = 1'b0;
    case (cmd)
      CMD_ALLOC: begin
        r.status = ST_FULL;
        for (n = 0; n < TBL_DEPTH && !done; n++) begin
          if (fat_table[n][FREE_BIT]) begin
            fat_table[n] = END_ENTRY;
            r.cluster = IDX_W'(n);
            r.status = ST_OK;
            done = 1'b1;
          end
        end
      end
      CMD_LINK: begin
        fat_table[idx] = {1'b0, nxt};
      end
      CMD_FREE: begin
        cur = idx;
        for (n = 0; n <= TBL_DEPTH && !done; n++) begin
          e = fat_table[cur];
          if (e[FREE_BIT]) begin
            r.status = ST_BROKEN;
            done = 1'b1;
          end else begin
            fat_table[cur] = FREE_ENTRY;
            if (e[IDX_W-1:0] == '0) done = 1'b1;
            else cur = e[IDX_W-1:0];
          end
        end
      end
      CMD_QUERY: begin
        e = fat_table[idx];
        if (e[FREE_BIT]) begin
          r.efree = 1'b1;
        end else begin
          r.cluster = e[IDX_W-1:0];
          r.eend = (e[IDX_W-1:0] == '0);
        end
      end
      CMD_FORMAT: begin
        for (n = 0; n < TBL_DEPTH; n++) fat_table[n] = FREE_ENTRY;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] rand_idx();
    return IDX_W'($urandom_range(TBL_DEPTH - 1));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= PRINT_LIMIT)
      $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch(name, got, want);
  endtask

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic [IDX_W-1:0] nxt, output res_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_cluster_index <= idx;
    in_next_index <= nxt;
    do @(posedge clk); while (in_stall);
    want = predict_fat_command(cmd, idx, nxt);
    pending_results.push_back(want);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_directed();
    res_t r;
    send_item(CMD_QUERY, '0, '0, r);
    send_item(CMD_QUERY, IDX_MAX, '0, r);
    send_item(CMD_ALLOC, '0, '0, r);
    send_item(CMD_ALLOC, IDX_MAX, IDX_MAX, r);
    send_item(CMD_LINK, 10'd1, 10'd2, r);
    send_item(CMD_LINK, 10'd2, IDX_MAX, r);
    send_item(CMD_LINK, IDX_MAX, '0, r);
    send_item(CMD_QUERY, 10'd1, '0, r);
    send_item(CMD_QUERY, IDX_MAX, '0, r);
    send_item(CMD_FREE, 10'd1, '0, r);
    send_item(CMD_QUERY, 10'd2, '0, r);
    // walk starting on a free entry
    send_item(CMD_FREE, 10'd5, '0, r);
    // two-entry loop
    send_item(CMD_LINK, 10'd3, 10'd4, r);
    send_item(CMD_LINK, 10'd4, 10'd3, r);
    send_item(CMD_FREE, 10'd3, '0, r);
    // root directory freed like any other
    send_item(CMD_FREE, '0, '0, r);
    send_item(CMD_QUERY, '0, '0, r);
    send_item(CMD_ALLOC, '0, '0, r);
    send_item(CMD_LINK, IDX_MAX, IDX_MAX, r);
    send_item(CMD_QUERY, IDX_MAX, IDX_MAX, r);
    send_item(CMD_FREE, IDX_MAX, IDX_MAX, r);
    send_item(CMD_FORMAT + 3'd1, IDX_MAX, IDX_MAX, r);
    send_item(CMD_TOP, IDX_MAX, '0, r);
    send_item(CMD_FORMAT, IDX_MAX, IDX_MAX, r);
    send_item(CMD_QUERY, '0, '0, r);
    send_item(CMD_ALLOC, '0, '0, r);
  endtask

  task automatic test_table_full();
    res_t r;
    logic [IDX_W-1:0] pick;
    int n;
    send_item(CMD_FORMAT, rand_idx(), rand_idx(), r);
    for (n = 0; n < TBL_DEPTH + 2; n++) send_item(CMD_ALLOC, rand_idx(), rand_idx(), r);
    for (n = 0; n < 4; n++) begin
      pick = rand_idx();
      send_item(CMD_QUERY, pick, rand_idx(), r);
      send_item(CMD_FREE, pick, rand_idx(), r);
      send_item(CMD_ALLOC, rand_idx(), rand_idx(), r);
      send_item(CMD_ALLOC, rand_idx(), rand_idx(), r);
    end
  endtask

  task automatic test_backpressure();
    res_t r;
    int n;
    hold_cycles = 400;
    for (n = 0; n < 40; n++) begin
      case ($urandom_range(2))
        0: send_item(CMD_QUERY, rand_idx(), rand_idx(), r);
        1: send_item(CMD_LINK, rand_idx(), rand_idx(), r);
        default: send_item(CMD_ALLOC, rand_idx(), rand_idx(), r);
      endcase
    end
  endtask

  task automatic build_and_free_chain();
    res_t r;
    logic [IDX_W-1:0] chain [$];
    int k;
    int n;
    int pick;
    k = $urandom_range(6, 1);
    for (n = 0; n < k; n++) begin
      send_item(CMD_ALLOC, rand_idx(), rand_idx(), r);
      if (r.status == ST_OK) chain.push_back(r.cluster);
    end
    if (chain.size() == 0) return;
    for (n = 0; n + 1 < chain.size(); n++) send_item(CMD_LINK, chain[n], chain[n+1], r);
    if ($urandom_range(1)) send_item(CMD_QUERY, chain[$urandom_range(chain.size() - 1)],
                                     rand_idx(), r);
    pick = $urandom_range(99);
    if (pick < 75) send_item(CMD_FREE, chain[0], rand_idx(), r);
    else if (pick < 90) send_item(CMD_FREE, chain[$urandom_range(chain.size() - 1)],
                                  rand_idx(), r);
    if ($urandom_range(1)) send_item(CMD_QUERY, chain[0], rand_idx(), r);
  endtask

  task automatic test_random(input int count);
    res_t r;
    int start;
    int pick;
    start = items_sent;
    while (items_sent - start < count) begin
      pick = $urandom_range(99);
      if (pick < 60) build_and_free_chain();
      else if (pick < 75) send_item(CMD_QUERY, rand_idx(), rand_idx(), r);
      else if (pick < 85) send_item(CMD_LINK, rand_idx(), rand_idx(), r);
      else if (pick < 93) send_item(CMD_FREE, rand_idx(), rand_idx(), r);
      else if (pick < 98) send_item(CMD_ALLOC, rand_idx(), rand_idx(), r);
      else if (pick < 99)
        send_item(CMD_W'($urandom_range(CMD_TOP, CMD_FORMAT + 1)), rand_idx(), rand_idx(), r);
      else send_item(CMD_FORMAT, rand_idx(), rand_idx(), r);
    end
  endtask

  // receiver side: random stall, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("transaction with nothing pending, status", out_status, 0);
      end else begin
        want = pending_results.pop_front();
        check_field("status", out_status, want.status);
        check_field("cluster_out", out_cluster_out, want.cluster);
        check_field("entry_free", out_entry_free, want.efree);
        check_field("entry_end", out_entry_end, want.eend);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles = idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int n;
    for (n = 0; n < TBL_DEPTH; n++) fat_table[n] = FREE_ENTRY;
    fat_table[0] = END_ENTRY;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_idling(0, 0);
    test_directed();
    set_idling(58, 0);
    test_table_full();
    set_idling(0, 0);
    test_backpressure();
    set_idling(0, 0);
    test_random(160);
    set_idling(58, 0);
    test_random(160);
    set_idling(0, 58);
    test_random(160);
    set_idling(15, 15);
    test_random(160);
    release_input();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/cca_pkg.sv
rtl/core/cca_table.sv
rtl/core/cca_out.sv
rtl/core/cca_ctrl.sv
rtl/core/cluster_chain_allocator.sv
tb/testbench.sv
